// ----- hw/rtl/bam_rss_pkg.sv -----
package bam_rss_pkg;

    localparam int unsigned HDR_BYTES = 36;

    typedef enum logic [2:0] {
        SEC_HEADER   = 3'd0,
        SEC_NAME     = 3'd1,
        SEC_NAME_END = 3'd2,
        SEC_CIGAR    = 3'd3,
        SEC_SEQ      = 3'd4,
        SEC_QUAL     = 3'd5,
        SEC_TAGS     = 3'd6
    } t_section;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] byte_out;
        t_section   section;
        logic       section_end;
        logic       record_end;
        t_status    status;
    } t_result;

endpackage

// ----- hw/rtl/bam_rss_core.sv -----
module bam_rss_core
    import bam_rss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_buffer_last,
    output t_result    o_result
);

    localparam logic [5:0] OFF_LEN0   = 6'd0;
    localparam logic [5:0] OFF_LEN1   = 6'd1;
    localparam logic [5:0] OFF_LEN2   = 6'd2;
    localparam logic [5:0] OFF_LEN3   = 6'd3;
    localparam logic [5:0] OFF_NAME   = 6'd12;
    localparam logic [5:0] OFF_CIGAR0 = 6'd16;
    localparam logic [5:0] OFF_CIGAR1 = 6'd17;
    localparam logic [5:0] OFF_SEQ0   = 6'd20;
    localparam logic [5:0] OFF_SEQ1   = 6'd21;
    localparam logic [5:0] OFF_SEQ2   = 6'd22;
    localparam logic [5:0] OFF_SEQ3   = 6'd23;
    localparam logic [5:0] OFF_SUM0   = 6'd24;
    localparam logic [5:0] OFF_SUM1   = 6'd25;
    localparam logic [5:0] OFF_FIXED  = 6'd26;
    localparam logic [5:0] OFF_TAGS   = 6'd27;

    logic [32:0] r_offset, n_offset;
    logic [32:0] r_rec_len, n_rec_len;
    logic [7:0]  r_name_len, n_name_len;
    logic [15:0] r_cigar, n_cigar;
    logic [31:0] r_seq_len, n_seq_len;
    t_section    r_section, n_section;
    logic [32:0] r_remain, n_remain;
    t_status     r_err, n_err;

    logic [31:0] r_seq_bytes, n_seq_bytes;
    logic [18:0] r_sum_a, n_sum_a;
    logic [32:0] r_sum_b, n_sum_b;
    logic [33:0] r_fixed, n_fixed;
    logic [32:0] r_tags_len, n_tags_len;

    logic        is_hdr;
    logic        send;
    logic        rend;
    logic [5:0]  off6;
    t_status     err;
    logic [6:0]  nz;
    logic [32:0] sec_size [7];
    logic [2:0]  next_idx;
    logic        next_found;

    assign is_hdr = (r_section == SEC_HEADER);
    assign send   = (r_remain == 33'd1);
    assign off6   = r_offset[5:0];
    assign rend   = !is_hdr && ((r_offset + 33'd1) == r_rec_len);

    always_comb begin
        err = ST_OK;
        if (is_hdr) begin
            if (send) begin
                if (i_buffer_last && (r_rec_len > 33'(HDR_BYTES))) begin
                    err = ST_TRUNCATED;
                end else if ((r_name_len == 8'd0) || (r_fixed > {1'b0, r_rec_len})) begin
                    err = ST_MALFORMED;
                end
            end else if (i_buffer_last) begin
                err = ST_TRUNCATED;
            end
        end else if (i_buffer_last && !rend) begin
            err = ST_TRUNCATED;
        end
    end

    always_comb begin
        nz[0] = 1'b0;
        nz[1] = (r_name_len > 8'd1);
        nz[2] = 1'b1;
        nz[3] = (r_cigar != 16'd0);
        nz[4] = (r_seq_len != 32'd0);
        nz[5] = (r_seq_len != 32'd0);
        nz[6] = (r_tags_len != 33'd0);
        sec_size[0] = 33'(HDR_BYTES);
        sec_size[1] = {25'd0, r_name_len - 8'd1};
        sec_size[2] = 33'd1;
        sec_size[3] = {15'd0, r_cigar, 2'b00};
        sec_size[4] = {1'b0, r_seq_bytes};
        sec_size[5] = {1'b0, r_seq_len};
        sec_size[6] = r_tags_len;
        next_idx   = 3'd0;
        next_found = 1'b0;
        for (int s = 6; s >= 1; s--) begin
            if ((3'(s) > r_section) && nz[s]) begin
                next_idx   = 3'(s);
                next_found = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.byte_out = i_data_byte;
        if (r_err != ST_OK) begin
            o_result.section     = SEC_HEADER;
            o_result.section_end = 1'b0;
            o_result.record_end  = 1'b0;
            o_result.status      = r_err;
        end else begin
            o_result.section     = r_section;
            o_result.section_end = send;
            o_result.record_end  = rend && (err == ST_OK);
            o_result.status      = err;
        end
    end

    always_comb begin
        n_offset    = r_offset;
        n_rec_len   = r_rec_len;
        n_name_len  = r_name_len;
        n_cigar     = r_cigar;
        n_seq_len   = r_seq_len;
        n_section   = r_section;
        n_remain    = r_remain;
        n_err       = r_err;
        n_seq_bytes = r_seq_bytes;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_fixed     = r_fixed;
        n_tags_len  = r_tags_len;
        if (i_accept && (r_err == ST_OK)) begin
            if (is_hdr) begin
                unique case (off6)
                    OFF_LEN0:   n_rec_len = {25'd0, i_data_byte};
                    OFF_LEN1:   n_rec_len[15:8] = i_data_byte;
                    OFF_LEN2:   n_rec_len[23:16] = i_data_byte;
                    OFF_LEN3:   n_rec_len = {1'b0, i_data_byte, r_rec_len[23:0]} + 33'd4;
                    OFF_NAME:   n_name_len = i_data_byte;
                    OFF_CIGAR0: n_cigar = {8'd0, i_data_byte};
                    OFF_CIGAR1: n_cigar[15:8] = i_data_byte;
                    OFF_SEQ0:   n_seq_len = {24'd0, i_data_byte};
                    OFF_SEQ1:   n_seq_len[15:8] = i_data_byte;
                    OFF_SEQ2:   n_seq_len[23:16] = i_data_byte;
                    OFF_SEQ3:   n_seq_len[31:24] = i_data_byte;
                    OFF_SUM0: begin
                        n_seq_bytes = 32'(({1'b0, r_seq_len} + 33'd1) >> 1);
                        n_sum_a     = 19'(HDR_BYTES) + {11'd0, r_name_len}
                                    + {1'b0, r_cigar, 2'b00};
                    end
                    OFF_SUM1:   n_sum_b = {1'b0, r_seq_bytes} + {1'b0, r_seq_len};
                    OFF_FIXED:  n_fixed = {15'd0, r_sum_a} + {1'b0, r_sum_b};
                    OFF_TAGS: begin
                        if ({1'b0, r_rec_len} > r_fixed) begin
                            n_tags_len = 33'({1'b0, r_rec_len} - r_fixed);
                        end else begin
                            n_tags_len = 33'd0;
                        end
                    end
                    default: ;
                endcase
            end
            if (err != ST_OK) begin
                n_err = err;
            end else if (rend) begin
                n_offset  = 33'd0;
                n_section = SEC_HEADER;
                n_remain  = 33'(HDR_BYTES);
            end else begin
                n_offset = r_offset + 33'd1;
                if (send) begin
                    n_section = t_section'(next_idx);
                    n_remain  = sec_size[next_idx];
                    if (!next_found) begin
                        n_offset = 33'd0;
                    end
                end else begin
                    n_remain = r_remain - 33'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_rec_len  <= '0;
            r_name_len <= '0;
            r_cigar    <= '0;
            r_seq_len  <= '0;
            r_section  <= SEC_HEADER;
            r_remain   <= 33'(HDR_BYTES);
            r_err      <= ST_OK;
        end else begin
            r_offset   <= n_offset;
            r_rec_len  <= n_rec_len;
            r_name_len <= n_name_len;
            r_cigar    <= n_cigar;
            r_seq_len  <= n_seq_len;
            r_section  <= n_section;
            r_remain   <= n_remain;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq_bytes <= n_seq_bytes;
        r_sum_a     <= n_sum_a;
        r_sum_b     <= n_sum_b;
        r_fixed     <= n_fixed;
        r_tags_len  <= n_tags_len;
    end

endmodule

// ----- hw/rtl/bam_record_section_splitter_unit.sv -----
// Channel   Dir  tdata            tuser                                   tlast
// s_axis    in   data_byte [7:0]  -                                       buffer_last
// m_axis    out  byte_out  [7:0]  section [2:0], section_end [3],          record_end
//                                 status [5:4]
//
// One word is accepted per clock unless the skid stage is full; its labeled word is registered.
// The section state and header length sums live in the labeling core and update on accept.
// A two-entry output register and skid stage let one more word be taken while output stalls.
// Reset is synchronous and active low and returns the parser to the start of a header.
// Errors are sticky until reset; later words pass through with the error status.
module bam_record_section_splitter_unit
    import bam_rss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte [7:0]
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // byte_out [7:0]
    output logic [5:0] m_axis_tuser,   // section [2:0], section_end [3], status [5:4]
    output logic       m_axis_tlast
);

    t_result res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    accept;
    logic    load_out;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_out      = !r_out_valid || m_axis_tready;

    bam_rss_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (s_axis_tdata),
        .i_buffer_last (s_axis_tlast),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (load_out) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.byte_out;
    assign m_axis_tuser  = {r_out.status, r_out.section_end, r_out.section};
    assign m_axis_tlast  = r_out.record_end;

endmodule

// ----- hw/rtl/bam_rss_checker.sv -----
module bam_rss_checker
    import bam_rss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [5:0] m_axis_tuser,
    input  logic       m_axis_tlast
);

    logic [1:0] r_err;
    logic       in_word;

    assign in_word = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= ST_OK;
        end else if (m_axis_tvalid && m_axis_tready && (m_axis_tuser[5:4] != ST_OK)) begin
            r_err <= m_axis_tuser[5:4];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_record_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[3] && (m_axis_tuser[5:4] == ST_OK)
            && (m_axis_tuser[2:0] != SEC_HEADER))
        else $error("record end outside a clean section end");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_err != ST_OK) |-> (m_axis_tuser[5:4] == r_err)
            && (m_axis_tuser[3:0] == 4'd0) && !m_axis_tlast)
        else $error("error status not held after an error word");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready || in_word |-> ##1 m_axis_tvalid)
        else $error("input stalled or taken without an output word following");

endmodule

bind bam_record_section_splitter_unit bam_rss_checker u_bam_rss_checker (.*);
